FILE: hw/rtl/baro_temp_pressure_compensation_unit_defines.svh
// ----------------------------------------------------------------------------
// Barometer compensation unit assertion macros
// Concurrent assertion forms used by the queue block of the unit.
// ----------------------------------------------------------------------------
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_UNIT_DEFINES_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BTPC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BTPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/btpc_pkg.sv
// ----------------------------------------------------------------------------
// Barometer compensation package
// Types, register indexes and constants shared by the compensation blocks.
// ----------------------------------------------------------------------------
package btpc_pkg;

    // Field widths.
    localparam int RAW_W  = 20;
    localparam int CAL_W  = 48;
    localparam int CENT_W = 15;
    localparam int PRES_W = 32;
    localparam int FINE_W = 32;
    localparam int TF_W   = 24;

    // Divider geometry: 64-bit dividend, 31-bit divisor magnitude.
    localparam int DIV_STAGES = 64;
    localparam int NUM_W      = 64;
    localparam int DEN_W      = 31;

    // Queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = QAW + 1;
    localparam logic [QCW-1:0] QCNT_FULL = QCW'(QDEPTH);

    // Configuration register indexes.
    localparam logic [1:0] CFG_TEMP    = 2'd0;
    localparam logic [1:0] CFG_PRESS_A = 2'd1;
    localparam logic [1:0] CFG_PRESS_B = 2'd2;
    localparam logic [1:0] CFG_PRESS_C = 2'd3;

    // Formula constants.
    localparam logic [24:0] FINE_OFFSET = 25'd128000;
    localparam logic [20:0] PRESS_BASE  = 21'd1048576;
    localparam logic [11:0] PRESS_SCALE = 12'd3125;
    localparam logic signed [18:0] CENTI_LIMIT = 19'sd10000;
    localparam logic [CENT_W-1:0] CENTI_SAT_POS = 15'd10001;
    localparam logic [CENT_W-1:0] CENTI_SAT_NEG = 15'h58EF;   // -10001
    localparam logic [50:0] W_BIAS = {4'b0001, 47'b0};        // 2^47
    localparam logic [PRES_W-1:0] PRES_MAX = '1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_TEMP_RANGE = 2'd1,
        ST_DIV_ZERO   = 2'd2
    } t_status;

    // Unpacked calibration words.
    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
    } t_calib;

    // Item handed from the front to the back.
    typedef struct packed {
        logic [RAW_W-1:0]  up;
        logic [TF_W-1:0]   tf;
        logic [CENT_W-1:0] centi;
        t_status           status;
    } t_qitem;

    typedef struct packed {
        logic   push;
        t_qitem item;
    } t_qpush;

    typedef struct packed {
        logic   valid;
        t_qitem item;
    } t_qhead;

    // Result fields that ride along the pressure pipeline.
    typedef struct packed {
        logic [FINE_W-1:0] fine;
        logic [CENT_W-1:0] centi;
        t_status           status;
    } t_tag;

endpackage

FILE: hw/rtl/btpc_queue.sv
// ----------------------------------------------------------------------------
// Compensation item queue
// Small FIFO that decouples the temperature front from the pressure back.
// ----------------------------------------------------------------------------
`include "baro_temp_pressure_compensation_unit_defines.svh"

module btpc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  btpc_pkg::t_qpush  i_wr,
    output logic              o_ready,
    input  logic              i_pop,
    output btpc_pkg::t_qhead  o_head
);
    import btpc_pkg::*;

    t_qitem         r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, n_wp;
    logic [QAW-1:0] r_rp, n_rp;
    logic [QCW-1:0] r_cnt, n_cnt;

    // Pointer and fill count update.
    always_comb begin
        n_wp  = i_wr.push ? r_wp + 1'b1 : r_wp;
        n_rp  = i_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (i_wr.push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_wr.push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Storage holds payload only.
    always_ff @(posedge i_clk) begin
        if (i_wr.push) begin
            r_mem[r_wp] <= i_wr.item;
        end
    end

    assign o_ready      = (r_cnt != QCNT_FULL);
    assign o_head.valid = (r_cnt != '0);
    assign o_head.item  = r_mem[r_rp];

    `BTPC_ASSERT_NOW(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= QCNT_FULL, "queue count above depth")
    `BTPC_ASSERT_NOW(a_pop_nonempty, i_clk, i_rst_n, i_pop, r_cnt != '0, "pop from empty queue")
    `BTPC_ASSERT_NOW(a_ptr_cnt, i_clk, i_rst_n, 1'b1, (r_wp - r_rp) == r_cnt[QAW-1:0], "pointers disagree with count")
    `BTPC_ASSERT_NEXT(a_cnt_inc, i_clk, i_rst_n, i_wr.push && !i_pop, r_cnt == $past(r_cnt) + 1'b1, "count did not grow on transfer in")

endmodule

FILE: hw/rtl/btpc_divider.sv
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per stage, 64 stages, carries a tag.
// ----------------------------------------------------------------------------
module btpc_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  btpc_pkg::t_tag              i_tag,
    input  logic                        i_neg,
    input  logic [btpc_pkg::NUM_W-1:0]  i_num,
    input  logic [btpc_pkg::DEN_W-1:0]  i_den,
    output logic                        o_valid,
    output btpc_pkg::t_tag              o_tag,
    output logic                        o_neg,
    output logic [btpc_pkg::NUM_W-1:0]  o_quot
);
    import btpc_pkg::*;

    logic             r_vld [DIV_STAGES];
    t_tag             r_tag [DIV_STAGES];
    logic             r_neg [DIV_STAGES];
    logic [DEN_W-1:0] r_den [DIV_STAGES];
    logic [DEN_W-1:0] r_rem [DIV_STAGES];
    logic [NUM_W-1:0] r_nq  [DIV_STAGES];

    logic [DEN_W-1:0] in_rem [DIV_STAGES];
    logic [NUM_W-1:0] in_nq  [DIV_STAGES];
    logic [DEN_W-1:0] in_den [DIV_STAGES];
    logic [DEN_W:0]   cat    [DIV_STAGES];
    logic [DEN_W:0]   sub    [DIV_STAGES];
    logic             ge     [DIV_STAGES];
    logic [DEN_W-1:0] n_rem  [DIV_STAGES];
    logic [NUM_W-1:0] n_nq   [DIV_STAGES];

    // One trial subtraction per stage; the dividend shifts out as quotient bits shift in.
    always_comb begin
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (s == 0) begin
                in_rem[s] = '0;
                in_nq[s]  = i_num;
                in_den[s] = i_den;
            end else begin
                in_rem[s] = r_rem[s-1];
                in_nq[s]  = r_nq[s-1];
                in_den[s] = r_den[s-1];
            end
            cat[s]   = {in_rem[s], in_nq[s][NUM_W-1]};
            sub[s]   = cat[s] - {1'b0, in_den[s]};
            ge[s]    = (cat[s] >= {1'b0, in_den[s]});
            n_rem[s] = ge[s] ? sub[s][DEN_W-1:0] : cat[s][DEN_W-1:0];
            n_nq[s]  = {in_nq[s][NUM_W-2:0], ge[s]};
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= i_tag;
            r_neg[0] <= i_neg;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_tag[s] <= r_tag[s-1];
                r_neg[s] <= r_neg[s-1];
            end
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_den[s] <= in_den[s];
                r_rem[s] <= n_rem[s];
                r_nq[s]  <= n_nq[s];
            end
        end
    end

    assign o_valid = r_vld[DIV_STAGES-1];
    assign o_tag   = r_tag[DIV_STAGES-1];
    assign o_neg   = r_neg[DIV_STAGES-1];
    assign o_quot  = r_nq[DIV_STAGES-1];

endmodule

FILE: hw/rtl/btpc_front.sv
// ----------------------------------------------------------------------------
// Temperature front
// Accepts raw readings, computes the fine temperature and the temperature in
// hundredths of a degree, classifies the range and pushes into the queue.
// ----------------------------------------------------------------------------
module btpc_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  btpc_pkg::t_calib             i_cal,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [btpc_pkg::RAW_W-1:0]   i_raw_pressure,
    input  logic [btpc_pkg::RAW_W-1:0]   i_raw_temperature,
    input  logic                         i_q_ready,
    output btpc_pkg::t_qpush             o_wr
);
    import btpc_pkg::*;

    localparam int NST = 6;

    logic              r_vld [NST];
    logic [RAW_W-1:0]  r_up  [NST-1];
    logic              en;

    logic [17:0]        r_a, n_a;
    logic [16:0]        r_d, n_d;
    logic signed [33:0] r_m1, n_m1;
    logic signed [33:0] r_dd, n_dd;
    logic [22:0]        r_v1t;
    logic signed [37:0] r_m2, n_m2;
    logic [TF_W-1:0]    r_tf4, n_tf;
    logic [TF_W-1:0]    r_tf5;
    logic [26:0]        s27;
    logic [18:0]        r_c;
    t_qitem             r_item, n_item;
    logic               gt, lt;

    // The whole front advances unless its last stage is blocked by a full queue.
    assign en      = !r_vld[NST-1] || i_q_ready;
    assign o_stall = !en;

    // Stage arithmetic.
    always_comb begin
        n_a  = {1'b0, i_raw_temperature[19:3]} - {1'b0, i_cal.t1, 1'b0};
        n_d  = {1'b0, i_raw_temperature[19:4]} - {1'b0, i_cal.t1};
        n_m1 = $signed(r_a) * $signed(i_cal.t2);
        n_dd = $signed(r_d) * $signed(r_d);
        n_m2 = $signed({1'b0, r_dd[32:12]}) * $signed(i_cal.t3);
        n_tf = {r_v1t[22], r_v1t} + r_m2[37:14];
        s27  = {{3{r_tf4[TF_W-1]}}, r_tf4} + {r_tf4[TF_W-1], r_tf4, 2'b00} + 27'd128;
    end

    // Range check and saturation of the temperature.
    always_comb begin
        gt             = ($signed(r_c) > CENTI_LIMIT);
        lt             = ($signed(r_c) < -CENTI_LIMIT);
        n_item.up      = r_up[NST-2];
        n_item.tf      = r_tf5;
        n_item.centi   = r_c[CENT_W-1:0];
        n_item.status  = ST_OK;
        if (gt) begin
            n_item.centi  = CENTI_SAT_POS;
            n_item.status = ST_TEMP_RANGE;
        end else if (lt) begin
            n_item.centi  = CENTI_SAT_NEG;
            n_item.status = ST_TEMP_RANGE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NST; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s < NST; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_up[0] <= i_raw_pressure;
            for (int s = 1; s < NST-1; s++) begin
                r_up[s] <= r_up[s-1];
            end
            r_a    <= n_a;
            r_d    <= n_d;
            r_m1   <= n_m1;
            r_dd   <= n_dd;
            r_v1t  <= r_m1[33:11];
            r_m2   <= n_m2;
            r_tf4  <= n_tf;
            r_tf5  <= r_tf4;
            r_c    <= s27[26:8];
            r_item <= n_item;
        end
    end

    assign o_wr.push = r_vld[NST-1] && i_q_ready;
    assign o_wr.item = r_item;

endmodule

FILE: hw/rtl/btpc_back.sv
// ----------------------------------------------------------------------------
// Pressure back
// Pops classified items, forms the pressure divisor and dividend, divides,
// applies the second-order correction and holds the result register.
// ----------------------------------------------------------------------------
module btpc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  btpc_pkg::t_calib              i_cal,
    input  btpc_pkg::t_qhead              i_head,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [btpc_pkg::CENT_W-1:0]   o_temperature_centi,
    output logic [btpc_pkg::PRES_W-1:0]   o_pressure_q24_8,
    output logic [btpc_pkg::FINE_W-1:0]   o_fine_temperature,
    output logic [1:0]                    o_status
);
    import btpc_pkg::*;

    localparam int NPRE  = 8;
    localparam int NPOST = 7;

    logic en;

    logic r_pre_vld  [NPRE];
    t_tag r_pre_tag  [NPRE];
    logic r_post_vld [NPOST];
    t_tag r_post_tag [NPOST];

    // Pre-divider stage registers.
    logic [21:0]        r_v1;
    logic [RAW_W-1:0]   r_up1, r_up2, r_up3, r_up4, r_up5;
    logic signed [43:0] r_vv;
    logic signed [37:0] r_vp5, r_vp2, r_vp5_3, r_vp2_3;
    logic signed [59:0] r_vv6, r_vv3;
    logic [63:0]        r_v2a, r_va, r_v2;
    logic [50:0]        r_w;
    logic [DEN_W-1:0]   r_den6, r_den7;
    logic [57:0]        r_diff;
    logic [63:0]        r_num;
    logic [NUM_W-1:0]   r_mag_n;
    logic [DEN_W-1:0]   r_mag_d;
    logic               r_neg;

    logic [24:0]        v1_full;
    logic signed [43:0] n_vv;
    logic signed [37:0] n_vp5, n_vp2;
    logic signed [59:0] n_vv6, n_vv3;
    logic signed [67:0] prodw;
    logic [20:0]        pb;
    logic [63:0]        n_diff;
    logic signed [70:0] prodn;
    t_tag               n_tag7;

    // Divider outputs.
    logic             dv_vld;
    t_tag             dv_tag;
    logic             dv_neg;
    logic [NUM_W-1:0] dv_quot;

    // Post-divider stage registers.
    logic [63:0]        r_p1, r_p2, r_p3;
    logic [63:0]        r_ppa;
    logic [30:0]        r_ppb;
    logic signed [48:0] r_mlo, r_ylo;
    logic [31:0]        r_mhi, r_yhi;
    logic [63:0]        r_xx, r_r2, r_pr2, r_pr2_5, r_r1, r_s, r_f;

    logic [63:0]        x;
    logic [31:0]        ppb_full;
    logic signed [48:0] n_mlo, n_ylo;
    logic [31:0]        n_mhi, n_yhi;
    logic [63:0]        r2raw, y;

    // Output register.
    logic              r_out_vld;
    logic [CENT_W-1:0] r_out_centi;
    logic [PRES_W-1:0] r_out_pres, n_out_pres;
    logic [FINE_W-1:0] r_out_fine;
    t_status           r_out_status;

    // Everything moves together whenever the result register can take a value.
    assign en    = !r_out_vld || !i_stall;
    assign o_pop = en && i_head.valid;

    // Divisor and dividend arithmetic.
    always_comb begin
        v1_full = {i_head.item.tf[TF_W-1], i_head.item.tf} - FINE_OFFSET;
        n_vv    = $signed(r_v1) * $signed(r_v1);
        n_vp5   = $signed(r_v1) * $signed(i_cal.p5);
        n_vp2   = $signed(r_v1) * $signed(i_cal.p2);
        n_vv6   = r_vv * $signed(i_cal.p6);
        n_vv3   = r_vv * $signed(i_cal.p3);
        prodw   = $signed(r_w) * $signed({1'b0, i_cal.p1});
        pb      = PRESS_BASE - {1'b0, r_up5};
        n_diff  = {12'b0, pb, 31'b0} - r_v2;
        prodn   = $signed(r_diff) * $signed({1'b0, PRESS_SCALE});
    end

    // Divisor zero only matters for items that passed the temperature check.
    always_comb begin
        n_tag7 = r_pre_tag[NPRE-2];
        if (n_tag7.status == ST_OK && r_den7 == '0) begin
            n_tag7.status = ST_DIV_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NPRE; s++) begin
                r_pre_vld[s] <= 1'b0;
            end
        end else if (en) begin
            r_pre_vld[0] <= i_head.valid;
            for (int s = 1; s < NPRE; s++) begin
                r_pre_vld[s] <= r_pre_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pre_tag[0] <= '{fine:   {{(FINE_W-TF_W){i_head.item.tf[TF_W-1]}}, i_head.item.tf},
                              centi:  i_head.item.centi,
                              status: i_head.item.status};
            for (int s = 1; s < NPRE-1; s++) begin
                r_pre_tag[s] <= r_pre_tag[s-1];
            end
            r_pre_tag[NPRE-1] <= n_tag7;

            r_v1    <= v1_full[21:0];
            r_up1   <= i_head.item.up;
            r_vv    <= n_vv;
            r_vp5   <= n_vp5;
            r_vp2   <= n_vp2;
            r_up2   <= r_up1;
            r_vv6   <= n_vv6;
            r_vv3   <= n_vv3;
            r_vp5_3 <= r_vp5;
            r_vp2_3 <= r_vp2;
            r_up3   <= r_up2;
            r_v2a   <= {{4{r_vv6[59]}}, r_vv6} + {{9{r_vp5_3[37]}}, r_vp5_3, 17'b0};
            r_va    <= {{12{r_vv3[59]}}, r_vv3[59:8]} + {{14{r_vp2_3[37]}}, r_vp2_3, 12'b0};
            r_up4   <= r_up3;
            r_v2    <= r_v2a + {{13{i_cal.p4[15]}}, i_cal.p4, 35'b0};
            r_w     <= r_va[50:0] + W_BIAS;
            r_up5   <= r_up4;
            r_den6  <= prodw[63:33];
            r_diff  <= n_diff[57:0];
            r_num   <= prodn[63:0];
            r_den7  <= r_den6;
            r_mag_n <= r_num[63] ? (64'd0 - r_num) : r_num;
            r_mag_d <= r_den7[DEN_W-1] ? ('0 - r_den7) : r_den7;
            r_neg   <= r_num[63] ^ r_den7[DEN_W-1];
        end
    end

    btpc_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_pre_vld[NPRE-1]),
        .i_tag   (r_pre_tag[NPRE-1]),
        .i_neg   (r_neg),
        .i_num   (r_mag_n),
        .i_den   (r_mag_d),
        .o_valid (dv_vld),
        .o_tag   (dv_tag),
        .o_neg   (dv_neg),
        .o_quot  (dv_quot)
    );

    // Second-order correction, 64-bit products split into 32-bit partial products.
    always_comb begin
        x        = {{13{r_p1[63]}}, r_p1[63:13]};
        ppb_full = x[31:0] * x[63:32];
        n_mlo    = $signed({1'b0, r_p1[31:0]}) * $signed(i_cal.p8);
        n_mhi    = r_p1[63:32] * {{16{i_cal.p8[15]}}, i_cal.p8};
        r2raw    = {{15{r_mlo[48]}}, r_mlo} + {r_mhi, 32'b0};
        n_ylo    = $signed({1'b0, r_xx[31:0]}) * $signed(i_cal.p9);
        n_yhi    = r_xx[63:32] * {{16{i_cal.p9[15]}}, i_cal.p9};
        y        = {{15{r_ylo[48]}}, r_ylo} + {r_yhi, 32'b0};
    end

    // Clamp to the unsigned Q24.8 field; any error gives zero.
    always_comb begin
        n_out_pres = r_f[31:0];
        if (r_post_tag[NPOST-1].status != ST_OK || r_f[63]) begin
            n_out_pres = '0;
        end else if (|r_f[62:32]) begin
            n_out_pres = PRES_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NPOST; s++) begin
                r_post_vld[s] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_post_vld[0] <= dv_vld;
            for (int s = 1; s < NPOST; s++) begin
                r_post_vld[s] <= r_post_vld[s-1];
            end
            r_out_vld <= r_post_vld[NPOST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_post_tag[0] <= dv_tag;
            for (int s = 1; s < NPOST; s++) begin
                r_post_tag[s] <= r_post_tag[s-1];
            end
            r_p1    <= dv_neg ? (64'd0 - dv_quot) : dv_quot;
            r_ppa   <= {32'b0, x[31:0]} * {32'b0, x[31:0]};
            r_ppb   <= ppb_full[30:0];
            r_mlo   <= n_mlo;
            r_mhi   <= n_mhi;
            r_p2    <= r_p1;
            r_xx    <= r_ppa + {r_ppb, 33'b0};
            r_r2    <= {{19{r2raw[63]}}, r2raw[63:19]};
            r_p3    <= r_p2;
            r_ylo   <= n_ylo;
            r_yhi   <= n_yhi;
            r_pr2   <= r_p3 + r_r2;
            r_r1    <= {{25{y[63]}}, y[63:25]};
            r_pr2_5 <= r_pr2;
            r_s     <= r_pr2_5 + r_r1;
            r_f     <= {{8{r_s[63]}}, r_s[63:8]} + {{44{i_cal.p7[15]}}, i_cal.p7, 4'b0};
            r_out_centi  <= r_post_tag[NPOST-1].centi;
            r_out_fine   <= r_post_tag[NPOST-1].fine;
            r_out_status <= r_post_tag[NPOST-1].status;
            r_out_pres   <= n_out_pres;
        end
    end

    assign o_valid             = r_out_vld;
    assign o_temperature_centi = r_out_centi;
    assign o_pressure_q24_8    = r_out_pres;
    assign o_fine_temperature  = r_out_fine;
    assign o_status            = r_out_status;

endmodule

FILE: hw/rtl/baro_temp_pressure_compensation_unit.sv
// ----------------------------------------------------------------------------
// Barometer temperature and pressure compensation unit
// Integer calibration of raw 20-bit readings: fine temperature, temperature in
// hundredths of a degree and pressure in Pa as unsigned Q24.8.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  input   | in        | i_valid / o_stall  | raw pressure, raw temperature
//  output  | out       | o_valid / i_stall  | centi temp, pressure, fine temp, status
//  config  | in        | i_cfg_we           | index 0..3, 48-bit calibration word
//
// One reading is taken per cycle while o_stall is low; the 64-stage divider is
// the longest part of the path from a transfer in to its result. Reset clears
// the calibration registers and all valid bits; there is no clearing pass. A
// stall on the output freezes the pressure back only; the temperature front
// keeps taking readings until the four-entry queue fills.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [btpc_pkg::CAL_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [btpc_pkg::RAW_W-1:0]    i_raw_pressure,
    input  logic [btpc_pkg::RAW_W-1:0]    i_raw_temperature,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [btpc_pkg::CENT_W-1:0]   o_temperature_centi,
    output logic [btpc_pkg::PRES_W-1:0]   o_pressure_q24_8,
    output logic [btpc_pkg::FINE_W-1:0]   o_fine_temperature,
    output logic [1:0]                    o_status
);
    import btpc_pkg::*;

    logic [CAL_W-1:0] r_cfg_temp, r_cfg_pa, r_cfg_pb, r_cfg_pc;
    t_calib           cal;
    t_qpush           q_wr;
    t_qhead           q_head;
    logic             q_ready;
    logic             q_pop;

    // Calibration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_temp <= '0;
            r_cfg_pa   <= '0;
            r_cfg_pb   <= '0;
            r_cfg_pc   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TEMP:    r_cfg_temp <= i_cfg_data;
                CFG_PRESS_A: r_cfg_pa   <= i_cfg_data;
                CFG_PRESS_B: r_cfg_pb   <= i_cfg_data;
                CFG_PRESS_C: r_cfg_pc   <= i_cfg_data;
                default:     r_cfg_temp <= r_cfg_temp;
            endcase
        end
    end

    // Unpack the twelve calibration words.
    always_comb begin
        cal.t1 = r_cfg_temp[15:0];
        cal.t2 = r_cfg_temp[31:16];
        cal.t3 = r_cfg_temp[47:32];
        cal.p1 = r_cfg_pa[15:0];
        cal.p2 = r_cfg_pa[31:16];
        cal.p3 = r_cfg_pa[47:32];
        cal.p4 = r_cfg_pb[15:0];
        cal.p5 = r_cfg_pb[31:16];
        cal.p6 = r_cfg_pb[47:32];
        cal.p7 = r_cfg_pc[15:0];
        cal.p8 = r_cfg_pc[31:16];
        cal.p9 = r_cfg_pc[47:32];
    end

    btpc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cal             (cal),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_temperature (i_raw_temperature),
        .i_q_ready         (q_ready),
        .o_wr              (q_wr)
    );

    btpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_head  (q_head)
    );

    btpc_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cal               (cal),
        .i_head              (q_head),
        .o_pop               (q_pop),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_temperature_centi (o_temperature_centi),
        .o_pressure_q24_8    (o_pressure_q24_8),
        .o_fine_temperature  (o_fine_temperature),
        .o_status            (o_status)
    );

endmodule

FILE: tb/baro_temp_pressure_compensation_unit_tb.sv
// ----------------------------------------------------------------------------
// Barometer compensation unit testbench
// Drives raw pressure and temperature readings under several calibration sets
// and idle and stall mixes, predicts each result with 64-bit integer arithmetic and
// compares every output transfer field by field in order.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_unit_tb;
    import btpc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;

    typedef struct packed {
        logic [CENT_W-1:0] centi;
        logic [PRES_W-1:0] pres;
        logic [FINE_W-1:0] fine;
        t_status           status;
    } t_comp;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [1:0]          i_cfg_index;
    logic [CAL_W-1:0]    i_cfg_data;
    logic                i_valid;
    logic                o_stall;
    logic [RAW_W-1:0]    i_raw_pressure;
    logic [RAW_W-1:0]    i_raw_temperature;
    logic                o_valid;
    logic                i_stall;
    logic [CENT_W-1:0]   o_temperature_centi;
    logic [PRES_W-1:0]   o_pressure_q24_8;
    logic [FINE_W-1:0]   o_fine_temperature;
    logic [1:0]          o_status;

    // Calibration copy used by the predictor.
    logic [CAL_W-1:0] cal_temp, cal_pa, cal_pb, cal_pc;
    t_comp            expected_q[$];
    int               errors;
    int               idle_pct;
    int               stall_pct;
    int               watchdog;
    int               readings_sent;
    int               results_seen;
    int               out_of_range_seen;
    int               div_zero_seen;

    baro_temp_pressure_compensation_unit dut (.*);

    // Clock.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic signed [63:0] sx16(logic [CAL_W-1:0] r, int idx);
        return 64'(signed'(r[16*idx +: 16]));
    endfunction

    // Integer compensation of one reading at 64 bits, wrapping.
    function automatic t_comp compensate(logic [RAW_W-1:0] up_raw,
                                         logic [RAW_W-1:0] ut_raw);
        logic signed [63:0] ut, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [63:0] a, d, v1, v2, tf, centi, p, r1, r2, num;
        t_comp c;
        ut = 64'(ut_raw);
        t1 = 64'(cal_temp[15:0]);
        t2 = sx16(cal_temp, 1);
        t3 = sx16(cal_temp, 2);
        p1 = 64'(cal_pa[15:0]);
        p2 = sx16(cal_pa, 1);
        p3 = sx16(cal_pa, 2);
        p4 = sx16(cal_pb, 0);
        p5 = sx16(cal_pb, 1);
        p6 = sx16(cal_pb, 2);
        p7 = sx16(cal_pc, 0);
        p8 = sx16(cal_pc, 1);
        p9 = sx16(cal_pc, 2);
        c.pres   = '0;
        c.status = ST_OK;
        a  = (ut >>> 3) - (t1 <<< 1);
        v1 = (a * t2) >>> 11;
        d  = (ut >>> 4) - t1;
        v2 = (((d * d) >>> 12) * t3) >>> 14;
        tf = v1 + v2;
        centi = (tf * 5 + 128) >>> 8;
        c.fine = tf[31:0];
        if (centi > 10000 || centi < -10000) begin
            c.status = ST_TEMP_RANGE;
            c.centi  = (centi > 0) ? CENTI_SAT_POS : CENTI_SAT_NEG;
        end else begin
            c.centi = centi[CENT_W-1:0];
            v1 = tf - 64'sd128000;
            v2 = v1 * v1 * p6;
            v2 = v2 + ((v1 * p5) <<< 17);
            v2 = v2 + (p4 <<< 35);
            v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
            v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
            if (v1 == 0) begin
                c.status = ST_DIV_ZERO;
            end else begin
                p   = 64'sd1048576 - 64'(up_raw);
                num = ((p <<< 31) - v2) * 64'sd3125;
                // The most negative value over minus one wraps to itself.
                if (num == {1'b1, 63'b0} && v1 == -64'sd1)
                    p = num;
                else
                    p = num / v1;
                r1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
                r2 = (p8 * p) >>> 19;
                p  = ((p + r1 + r2) >>> 8) + (p7 <<< 4);
                if (p < 0)
                    c.pres = '0;
                else if (p > 64'sd4294967295)
                    c.pres = PRES_MAX;
                else
                    c.pres = p[31:0];
            end
        end
        return c;
    endfunction

    // Sends one reading and queues its expected result on transfer.
    // Valid stays high after the transfer so that readings can follow back to back.
    task automatic send_reading(logic [RAW_W-1:0] up, logic [RAW_W-1:0] ut);
        while (($urandom_range(99, 0)) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid           <= 1'b1;
        i_raw_pressure    <= up;
        i_raw_temperature <= ut;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_q.push_back(compensate(up, ut));
        readings_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cal(logic [1:0] idx, logic [CAL_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        case (idx)
            CFG_TEMP:    cal_temp = val;
            CFG_PRESS_A: cal_pa   = val;
            CFG_PRESS_B: cal_pb   = val;
            default:     cal_pc   = val;
        endcase
    endtask

    task automatic load_cal(logic [CAL_W-1:0] t, logic [CAL_W-1:0] a,
                            logic [CAL_W-1:0] b, logic [CAL_W-1:0] c);
        wait_idle();
        write_cal(CFG_TEMP, t);
        write_cal(CFG_PRESS_A, a);
        write_cal(CFG_PRESS_B, b);
        write_cal(CFG_PRESS_C, c);
        i_cfg_we <= 1'b0;
    endtask

    // Typical factory calibration, packed low word first.
    task automatic load_typical_cal();
        load_cal({16'(-16'sd1000), 16'sd26435, 16'd27504},
                 {16'sd3024, 16'(-16'sd10685), 16'd36477},
                 {16'(-16'sd7), 16'(-16'sd1225), 16'sd2855},
                 {16'sd4000, 16'(-16'sd14600), 16'sd15500});
    endtask

    function automatic logic [CAL_W-1:0] rand_cal();
        return {16'($urandom), 16'($urandom), 16'($urandom)};
    endfunction

    // Reset calibration: all zero, divisor zero on every in-range reading.
    task automatic test_reset_cal();
        send_reading('0, '0);
        send_reading('1, '1);
    endtask

    // Field extremes, temperature saturation both ways and zero divisor.
    task automatic test_directed();
        load_typical_cal();
        send_reading('0, '0);
        send_reading('1, '1);
        send_reading(20'd415148, 20'd519888);
        send_reading(20'h80000, 20'h80000);
        send_reading(20'd300000, 20'd400000);
        send_reading(20'd600000, 20'd600000);
        send_reading(20'h55555, 20'hAAAAA);
        send_reading(20'hAAAAA, 20'h55555);
        // Strong negative curvature pushes the temperature far below range.
        load_cal({16'h8000, 16'h7FFF, 16'hFFFF}, '1, '1, '1);
        send_reading('0, '0);
        send_reading('1, '1);
        send_reading(20'd1000, 20'd700000);
        // Divisor zero: P1 of zero with a plain temperature.
        load_cal({16'd0, 16'd1, 16'd27504}, {16'd7, 16'd9, 16'd0}, '0, '0);
        send_reading(20'd415148, 20'd519888);
        send_reading('1, 20'd440000);
        // Extreme words everywhere.
        load_cal({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'hFFFF},
                 {16'h8000, 16'h8000, 16'h8000}, {16'h7FFF, 16'h7FFF, 16'h7FFF});
        send_reading('0, '0);
        send_reading('1, '1);
        send_reading(20'd500000, 20'd500000);
        load_cal({16'h7FFF, 16'h7FFF, 16'h0000}, {16'h7FFF, 16'h7FFF, 16'h0001},
                 {16'h7FFF, 16'h7FFF, 16'h7FFF}, {16'h8000, 16'h8000, 16'h8000});
        send_reading('0, '0);
        send_reading('1, '1);
        send_reading(20'd500000, 20'd500000);
    endtask

    // Random readings under a given idle and stall mix.
    task automatic test_random(int n, int idle, int stall, bit random_cal);
        wait_idle();
        idle_pct  = idle;
        stall_pct = stall;
        if (random_cal)
            load_cal(rand_cal(), rand_cal(), rand_cal(), rand_cal());
        else
            load_typical_cal();
        for (int k = 0; k < n; k++) begin
            if (random_cal || ($urandom_range(3, 0) == 0))
                send_reading(20'($urandom), 20'($urandom));
            else
                send_reading(20'($urandom_range(500000, 250000)),
                             20'($urandom_range(560000, 470000)));
        end
    endtask

    // Output stall driven at the falling edge.
    always @(negedge i_clk) begin
        if (i_rst_n)
            i_stall <= ($urandom_range(99, 0) < stall_pct);
    end

    // Result check at each output transfer.
    always @(posedge i_clk) begin
        t_comp e;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                $error("result with no reading outstanding");
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (e.status == ST_TEMP_RANGE) out_of_range_seen++;
                if (e.status == ST_DIV_ZERO) div_zero_seen++;
                if (o_temperature_centi !== e.centi) begin
                    $error("temperature_centi expected %h actual %h",
                           e.centi, o_temperature_centi);
                    errors++;
                end
                if (o_pressure_q24_8 !== e.pres) begin
                    $error("pressure_q24_8 expected %h actual %h",
                           e.pres, o_pressure_q24_8);
                    errors++;
                end
                if (o_fine_temperature !== e.fine) begin
                    $error("fine_temperature expected %h actual %h",
                           e.fine, o_fine_temperature);
                    errors++;
                end
                if (o_status !== e.status) begin
                    $error("status expected %0d actual %0d", e.status, o_status);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we)
            watchdog <= 0;
        else if (expected_q.size() != 0 || i_valid)
            watchdog <= watchdog + 1;
        if (watchdog >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        errors = 0; idle_pct = 0; stall_pct = 0; watchdog = 0;
        readings_sent = 0; results_seen = 0;
        out_of_range_seen = 0; div_zero_seen = 0;
        cal_temp = '0; cal_pa = '0; cal_pb = '0; cal_pc = '0;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        i_valid = 1'b0; i_raw_pressure = '0; i_raw_temperature = '0;
        i_stall = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_cal();
        test_directed();
        test_random(250, 0, 0, 1'b0);
        test_random(120, 85, 0, 1'b1);
        test_random(120, 0, 85, 1'b0);
        test_random(250, 13, 13, 1'b1);
        test_random(150, 0, 0, 1'b1);
        test_random(120, 13, 13, 1'b0);
        wait_idle();
        $display("Sent %0d readings, checked %0d results (%0d out of range, %0d zero divisor).",
                 readings_sent, results_seen, out_of_range_seen, div_zero_seen);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/btpc_pkg.sv
hw/rtl/btpc_queue.sv
hw/rtl/btpc_divider.sv
hw/rtl/btpc_front.sv
hw/rtl/btpc_back.sv
hw/rtl/baro_temp_pressure_compensation_unit.sv
tb/baro_temp_pressure_compensation_unit_tb.sv
